// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    localparam int PIX_W       = 8;
    localparam int COL_OUT_W   = 11;
    localparam int ROW_W       = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int GRAD_W      = 11;
    localparam int MAG_W       = 11;

    localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH      = 12'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT     = 12'd480;
    localparam logic [CFG_DATA_W-1:0] MIN_SIZE         = 12'd3;
    localparam logic [PIX_W-1:0]      EDGE_MAX         = 8'd255;

    typedef struct packed {
        logic                 emit;
        logic                 border;
        logic                 last;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
    } t_tag;

    typedef struct packed {
        logic [PIX_W-1:0]     edge_value;
        logic [COL_OUT_W-1:0] out_col;
        logic [ROW_W-1:0]     out_row;
        logic                 frame_done;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/sem_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/sem_kernel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sem_kernel (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire sem_pkg::t_tag          i_tag,
    input  wire logic [sem_pkg::PIX_W-1:0] i_pixel,
    input  wire logic [sem_pkg::PIX_W-1:0] i_upper,
    input  wire logic [sem_pkg::PIX_W-1:0] i_middle,
    output logic                        o_push,
    output sem_pkg::t_result            o_result,
    output logic [1:0]                  o_pend
);

    import sem_pkg::*;

    logic [PIX_W-1:0]         r_win [3][3];
    logic                     r_v2;
    t_tag                     r_tag2;
    logic                     r_v3;
    t_tag                     r_tag3;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;

    logic [GRAD_W-1:0]        gx_pos;
    logic [GRAD_W-1:0]        gx_neg;
    logic [GRAD_W-1:0]        gy_pos;
    logic [GRAD_W-1:0]        gy_neg;
    logic signed [GRAD_W-1:0] n_gx;
    logic signed [GRAD_W-1:0] n_gy;
    logic [MAG_W-1:0]         abs_gx;
    logic [MAG_W-1:0]         abs_gy;
    logic [MAG_W-1:0]         mag;
    logic [PIX_W-1:0]         edge_val;

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_upper;
            r_win[1][2] <= i_middle;
            r_win[2][2] <= i_pixel;
        end
    end

    always_comb begin
        gx_pos = GRAD_W'(r_win[0][2]) + (GRAD_W'(r_win[1][2]) << 1) + GRAD_W'(r_win[2][2]);
        gx_neg = GRAD_W'(r_win[0][0]) + (GRAD_W'(r_win[1][0]) << 1) + GRAD_W'(r_win[2][0]);
        gy_pos = GRAD_W'(r_win[2][0]) + (GRAD_W'(r_win[2][1]) << 1) + GRAD_W'(r_win[2][2]);
        gy_neg = GRAD_W'(r_win[0][0]) + (GRAD_W'(r_win[0][1]) << 1) + GRAD_W'(r_win[0][2]);
        n_gx   = signed'(gx_pos - gx_neg);
        n_gy   = signed'(gy_pos - gy_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag2 <= i_tag;
        r_tag3 <= r_tag2;
        r_gx   <= n_gx;
        r_gy   <= n_gy;
    end

    always_comb begin
        abs_gx = r_gx[GRAD_W-1] ? MAG_W'(-r_gx) : MAG_W'(r_gx);
        abs_gy = r_gy[GRAD_W-1] ? MAG_W'(-r_gy) : MAG_W'(r_gy);
        mag    = abs_gx + abs_gy;
        if (r_tag3.border) begin
            edge_val = '0;
        end else if (mag > MAG_W'(EDGE_MAX)) begin
            edge_val = EDGE_MAX;
        end else begin
            edge_val = mag[PIX_W-1:0];
        end
    end

    assign o_push              = r_v3 && r_tag3.emit;
    assign o_result.edge_value = edge_val;
    assign o_result.out_col    = r_tag3.col;
    assign o_result.out_row    = r_tag3.row;
    assign o_result.frame_done = r_tag3.last;
    assign o_pend              = 2'(r_v2 && r_tag2.emit) + 2'(r_v3 && r_tag3.emit);

endmodule

`default_nettype wire

// ===== rtl/sem_ofifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sem_ofifo (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire sem_pkg::t_result           i_data,
    input  wire logic                       i_pop,
    output logic                            o_valid,
    output sem_pkg::t_result                o_data,
    output logic [sem_pkg::OFIFO_AW:0]      o_count
);

    import sem_pkg::*;

    t_result               r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wptr;
    logic [OFIFO_AW-1:0]   r_rptr;
    logic [OFIFO_AW:0]     r_count;
    logic                  pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (OFIFO_AW + 1)'(i_push) - (OFIFO_AW + 1)'(pop_ok);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < (OFIFO_AW + 1)'(OFIFO_DEPTH)))
        else $error("output queue written while full");

endmodule

`default_nettype wire

// ===== rtl/sobel_edge_magnitude_top.sv =====
// A result passes through the input register, the kernel window, the gradient register and the output queue.
// The result for center (c-1, r-1) is produced by the pixel at (c, r); none for row 0 or column 0.
// Throughput: one pixel per cycle while o_stall is low, set by the single read and write port pair of the line RAM.
// Up to eight results are buffered; input stalls only when the buffer and pipeline fill up.
// Reset clears counters, pipeline and queue and restores 640 x 480; line RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [sem_pkg::PIX_W-1:0]           i_pixel,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [sem_pkg::PIX_W-1:0]                o_edge_value,
    output logic [sem_pkg::COL_OUT_W-1:0]            o_out_col,
    output logic [sem_pkg::ROW_W-1:0]                o_out_row,
    output logic                                     o_frame_done
);

    import sem_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW >= 12) ? CW + 1 : 13;

    logic [CFG_DATA_W-1:0] r_img_w;
    logic [CFG_DATA_W-1:0] r_img_h;
    logic [CW-1:0]         r_col;
    logic [ROW_W-1:0]      r_row;
    logic                  r_v1;
    logic [CW-1:0]         r_addr1;
    logic [PIX_W-1:0]      r_pix1;
    t_tag                  r_tag1;

    logic [CW-1:0]         n_col;
    logic [ROW_W-1:0]      n_row;
    logic                  accept;
    logic [CMPW-1:0]       wreg;
    logic [CMPW-1:0]       eff_w;
    logic [ROW_W:0]        eff_h;
    logic [CMPW-1:0]       col_inc;
    logic [ROW_W:0]        row_inc;
    t_tag                  tag0;
    logic [2*PIX_W-1:0]    ram_rdata;
    logic                  k_push;
    t_result               k_result;
    logic [1:0]            k_pend;
    t_result               q_data;
    logic [OFIFO_AW:0]     q_count;
    logic [OFIFO_AW+1:0]   credit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RESET_WIDTH;
            r_img_h <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        wreg = CMPW'(r_img_w);
        if (wreg < CMPW'(MIN_SIZE)) begin
            eff_w = CMPW'(MIN_SIZE);
        end else if (wreg > CMPW'(MAX_WIDTH)) begin
            eff_w = CMPW'(MAX_WIDTH);
        end else begin
            eff_w = wreg;
        end
        eff_h   = (r_img_h < MIN_SIZE) ? (ROW_W + 1)'(MIN_SIZE) : (ROW_W + 1)'(r_img_h);
        col_inc = CMPW'(r_col) + CMPW'(1);
        row_inc = (ROW_W + 1)'(r_row) + (ROW_W + 1)'(1);

        if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = r_row;
        end

        tag0.emit   = (r_col != '0) && (r_row != '0);
        tag0.border = (r_col == CW'(1)) || (r_row == ROW_W'(1));
        tag0.last   = (col_inc == eff_w) && (row_inc == eff_h);
        tag0.col    = COL_OUT_W'(r_col - CW'(1));
        tag0.row    = r_row - ROW_W'(1);
    end

    assign credit  = (OFIFO_AW + 2)'(q_count) + (OFIFO_AW + 2)'(k_pend)
                   + (OFIFO_AW + 2)'(r_v1 && r_tag1.emit);
    assign o_stall = (credit >= (OFIFO_AW + 2)'(OFIFO_DEPTH));
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
        end else begin
            r_v1 <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr1 <= r_col;
            r_pix1  <= i_pixel;
            r_tag1  <= tag0;
        end
    end

    sem_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_v1),
        .i_waddr (r_addr1),
        .i_wdata ({ram_rdata[PIX_W-1:0], r_pix1}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    sem_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_tag    (r_tag1),
        .i_pixel  (r_pix1),
        .i_upper  (ram_rdata[2*PIX_W-1:PIX_W]),
        .i_middle (ram_rdata[PIX_W-1:0]),
        .o_push   (k_push),
        .o_result (k_result),
        .o_pend   (k_pend)
    );

    sem_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (k_push),
        .i_data  (k_result),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_edge_value = q_data.edge_value;
    assign o_out_col    = q_data.out_col;
    assign o_out_row    = q_data.out_row;
    assign o_frame_done = q_data.frame_done;

    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_v1) |-> (r_col != r_addr1))
        else $error("line RAM read and write hit the same entry");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        credit <= (OFIFO_AW + 2)'(OFIFO_DEPTH))
        else $error("results in flight exceed output queue space");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (CMPW'(r_col) < CMPW'(MAX_WIDTH)))
        else $error("column counter beyond line RAM depth");

endmodule

`default_nettype wire
